[hdl/assert_macros.svh]
// Shared assertion macros for the trace detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HTD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define HTD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/htd_pkg.sv]
`default_nettype none
package htd_pkg;

	localparam int COUNTER_ENTRIES = 1024;
	localparam int CNT_IDX_W = $clog2(COUNTER_ENTRIES);
	localparam int ADDR_BITS = 16;

	localparam logic [7:0] TRACE_ENTRIES = 8'd128;
	localparam logic [7:0] CNT_MAX = 8'hFF;
	localparam logic [7:0] CLOSE_OP = 8'h5D;

	localparam logic [7:0] HOT_THRESHOLD_RST = 8'd100;
	localparam logic [3:0] BACKEDGE_LIMIT_RST = 4'd5;

	localparam logic [0:0] CFG_HOT_THRESHOLD = 1'b0;
	localparam logic [0:0] CFG_BACKEDGE_LIMIT = 1'b1;

	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_SIMPLE = 1'b1;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_START = 3'd1,
		EV_REC = 3'd2,
		EV_COMMIT = 3'd3,
		EV_FULL = 3'd4,
		EV_RESTART = 3'd5,
		EV_BACKEDGE = 3'd6
	} ev_t;

endpackage
`default_nettype wire

[hdl/hot_trace_detector_recorder.sv]
// An accepted item's result is registered into the output payload when stage 1 fires.
// Throughput: one item per cycle while the output is not stalled; the counter RAM is read at
// accept and written back when stage 1 fires, with the written value forwarded to a following
// item on the same slot. Reset: control state clears at once, then the counter RAM is zeroed
// one entry per cycle with in_ready low; configuration writes are taken throughout.
`default_nettype none
`include "assert_macros.svh"
module hot_trace_detector_recorder
	import htd_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic cmd,
	input wire logic [ADDR_BITS-1:0] pc,
	input wire logic [7:0] opcode,
	input wire logic [ADDR_BITS-1:0] next_pc,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] event_res,
	output logic [15:0] header_address,
	output logic [7:0] entry_index,
	output logic [7:0] entry_opcode,
	output logic [15:0] entry_address
);

	// configuration
	logic [7:0] hot_threshold_q;
	logic [3:0] backedge_limit_q;

	// control state
	logic rec_q;
	logic [ADDR_BITS-1:0] header_q;
	logic [7:0] fill_q;
	logic [4:0] be_q;

	// clearing pass
	logic clear_q;
	logic [CNT_IDX_W-1:0] clr_idx_q;

	// stage 1
	logic v_s1;
	logic cmd_s1;
	logic [ADDR_BITS-1:0] pc_s1;
	logic [7:0] opcode_s1;
	logic [ADDR_BITS-1:0] next_pc_s1;
	logic [7:0] rd_s1;
	logic fwd_s1;
	logic [7:0] fwd_s1_data;

	logic [7:0] cnt_mem [COUNTER_ENTRIES];

	logic in_fire;
	logic s1_fire;
	logic [CNT_IDX_W-1:0] in_slot;
	logic [CNT_IDX_W-1:0] s1_slot;

	// stage 1 results
	logic [7:0] cnt_cur;
	logic [7:0] cnt_inc;
	logic hot;
	logic full;
	logic be_hit;
	logic [4:0] be_inc;
	logic prof_we;
	ev_t ev_n;
	logic rec_n;
	logic [ADDR_BITS-1:0] header_n;
	logic [7:0] fill_n;
	logic [4:0] be_n;
	logic [7:0] idx_n;
	logic [7:0] eop_n;
	logic [15:0] eaddr_n;

	logic mem_we;
	logic [CNT_IDX_W-1:0] mem_waddr;
	logic [7:0] mem_wdata;

	assign s1_fire = v_s1 && (!out_valid || out_ready);
	assign in_ready = !clear_q && (!v_s1 || s1_fire);
	assign in_fire = in_valid && in_ready;
	assign in_slot = pc[CNT_IDX_W-1:0];
	assign s1_slot = pc_s1[CNT_IDX_W-1:0];

	assign cnt_cur = fwd_s1 ? fwd_s1_data : rd_s1;
	assign cnt_inc = (cnt_cur == CNT_MAX) ? CNT_MAX : cnt_cur + 8'd1;
	assign hot = cnt_inc > hot_threshold_q;
	assign full = fill_q >= TRACE_ENTRIES;
	assign be_hit = (opcode_s1 == CLOSE_OP) && (next_pc_s1 != header_q);
	assign be_inc = be_q + 5'd1;

	always_comb begin
		ev_n = EV_NONE;
		rec_n = rec_q;
		header_n = header_q;
		fill_n = fill_q;
		be_n = be_q;
		idx_n = 8'd0;
		eop_n = 8'd0;
		eaddr_n = 16'd0;
		prof_we = 1'b0;
		if (cmd_s1 == CMD_HEADER) begin
			if (rec_q && !full) begin
				idx_n = fill_q;
				eop_n = opcode_s1;
				eaddr_n = pc_s1[15:0];
				fill_n = fill_q + 8'd1;
				if (next_pc_s1 == header_q) begin
					rec_n = 1'b0;
					ev_n = EV_COMMIT;
				end else begin
					ev_n = EV_REC;
				end
			end else begin
				// profile the step, also after a full abort
				prof_we = 1'b1;
				rec_n = 1'b0;
				ev_n = rec_q ? EV_FULL : EV_NONE;
				if (hot) begin
					header_n = pc_s1;
					fill_n = 8'd1;
					be_n = 5'd0;
					rec_n = 1'b1;
					ev_n = rec_q ? EV_RESTART : EV_START;
					eop_n = opcode_s1;
					eaddr_n = pc_s1[15:0];
				end
			end
		end else if (rec_q) begin
			if (be_hit && (be_inc > {1'b0, backedge_limit_q})) begin
				be_n = 5'd0;
				rec_n = 1'b0;
				ev_n = EV_BACKEDGE;
			end else begin
				if (be_hit) begin
					be_n = be_inc;
				end
				if (full) begin
					rec_n = 1'b0;
					ev_n = EV_FULL;
				end else begin
					idx_n = fill_q;
					eop_n = opcode_s1;
					eaddr_n = pc_s1[15:0];
					fill_n = fill_q + 8'd1;
					if (next_pc_s1 == header_q) begin
						rec_n = 1'b0;
						ev_n = EV_COMMIT;
					end else begin
						ev_n = EV_REC;
					end
				end
			end
		end
	end

	assign mem_we = clear_q || (s1_fire && prof_we);
	assign mem_waddr = clear_q ? clr_idx_q : s1_slot;
	assign mem_wdata = clear_q ? 8'd0 : cnt_inc;

	// counter RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cnt_mem[mem_waddr] <= mem_wdata;
		end
		if (in_fire) begin
			rd_s1 <= cnt_mem[in_slot];
		end
	end

	// stage 1 payload, with forwarding of a write that lands on the same edge
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1 <= cmd;
			pc_s1 <= pc;
			opcode_s1 <= opcode;
			next_pc_s1 <= next_pc;
			fwd_s1 <= s1_fire && prof_we && (s1_slot == in_slot);
			fwd_s1_data <= cnt_inc;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			event_res <= ev_n;
			header_address <= header_n[15:0];
			entry_index <= idx_n;
			entry_opcode <= eop_n;
			entry_address <= eaddr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_threshold_q <= HOT_THRESHOLD_RST;
			backedge_limit_q <= BACKEDGE_LIMIT_RST;
			rec_q <= 1'b0;
			header_q <= '0;
			fill_q <= 8'd0;
			be_q <= 5'd0;
			clear_q <= 1'b1;
			clr_idx_q <= '0;
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_HOT_THRESHOLD: hot_threshold_q <= cfg_data;
					CFG_BACKEDGE_LIMIT: backedge_limit_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (clear_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == CNT_IDX_W'(COUNTER_ENTRIES - 1)) begin
					clear_q <= 1'b0;
				end
			end
			if (s1_fire) begin
				rec_q <= rec_n;
				header_q <= header_n;
				fill_q <= fill_n;
				be_q <= be_n;
			end
			if (in_fire) begin
				v_s1 <= 1'b1;
			end else if (s1_fire) begin
				v_s1 <= 1'b0;
			end
			if (s1_fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	`HTD_ASSERT(a_no_accept_clear, in_valid && in_ready |-> !clear_q, "item accepted during clear")
	`HTD_ASSERT(a_fill_range, rec_q |-> (fill_q >= 8'd1) && (fill_q <= TRACE_ENTRIES), "fill out of range")
	`HTD_ASSERT(a_start_entry, out_valid && ((event_res == EV_START) || (event_res == EV_RESTART)) |-> (entry_index == 8'd0) && (entry_address == header_address), "start entry mismatch")
	`HTD_ASSERT(a_out_from_s1, $rose(out_valid) |-> $past(v_s1), "result without item")
	`HTD_ASSERT(a_we_exclusive, !(clear_q && v_s1), "item in flight during clear")

endmodule
`default_nettype wire

[tb/trace_event_check.sv]
`timescale 1ns / 1ps
module trace_event_check
	import htd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data,
	input logic in_valid,
	input logic in_ready,
	input logic cmd,
	input logic [ADDR_BITS-1:0] pc,
	input logic [7:0] opcode,
	input logic [ADDR_BITS-1:0] next_pc,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] event_res,
	input logic [15:0] header_address,
	input logic [7:0] entry_index,
	input logic [7:0] entry_opcode,
	input logic [15:0] entry_address,
	output int mismatches,
	output int pending,
	output int n_results,
	output int n_started,
	output int n_committed,
	output int n_aborted
);

	typedef struct packed {
		ev_t ev;
		logic [15:0] hdr;
		logic [7:0] idx;
		logic [7:0] op;
		logic [15:0] addr;
	} trace_res_t;

	// Shadow copy of the detector state
	logic [7:0] threshold;
	logic [3:0] be_limit;
	bit recording;
	logic [7:0] hot_count [COUNTER_ENTRIES];
	logic [ADDR_BITS-1:0] head_pc;
	logic [7:0] fill;
	logic [4:0] be_seen;

	trace_res_t expected_events[$];

	// Bump the heat counter of a header; start recording once it passes the threshold.
	function automatic bit bump_heat(input logic [ADDR_BITS-1:0] a);
		int slot;
		logic [7:0] c;
		slot = int'(a) % COUNTER_ENTRIES;
		c = hot_count[slot];
		if (c != CNT_MAX)
			c = c + 8'd1;
		hot_count[slot] = c;
		if (c > threshold) begin
			head_pc = a;
			fill = 8'd1;
			be_seen = '0;
			recording = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic trace_res_t predict_trace_step(input logic c, input logic [ADDR_BITS-1:0] a,
			input logic [7:0] op, input logic [ADDR_BITS-1:0] npc);
		trace_res_t r;
		bit do_write;
		r = '0;
		r.ev = EV_NONE;
		do_write = 1'b0;
		if (c == CMD_HEADER) begin
			if (recording) begin
				if (fill >= TRACE_ENTRIES) begin
					// buffer full: drop the trace and profile this header at once
					recording = 1'b0;
					if (bump_heat(a)) begin
						r.ev = EV_RESTART;
						r.op = op;
						r.addr = 16'(a);
					end else begin
						r.ev = EV_FULL;
					end
				end else begin
					do_write = 1'b1;
				end
			end else if (bump_heat(a)) begin
				r.ev = EV_START;
				r.op = op;
				r.addr = 16'(a);
			end
		end else if (recording) begin
			do_write = 1'b1;
			if (op == CLOSE_OP && npc != head_pc) begin
				be_seen = be_seen + 5'd1;
				if (be_seen > 5'(be_limit)) begin
					be_seen = '0;
					recording = 1'b0;
					r.ev = EV_BACKEDGE;
					do_write = 1'b0;
				end
			end
			if (do_write && fill >= TRACE_ENTRIES) begin
				recording = 1'b0;
				r.ev = EV_FULL;
				do_write = 1'b0;
			end
		end
		if (do_write) begin
			r.idx = fill;
			r.op = op;
			r.addr = 16'(a);
			fill = fill + 8'd1;
			if (npc == head_pc) begin
				recording = 1'b0;
				r.ev = EV_COMMIT;
			end else begin
				r.ev = EV_REC;
			end
		end
		r.hdr = 16'(head_pc);
		return r;
	endfunction

	task automatic flag(input string what, input logic [15:0] want, input logic [15:0] seen);
		mismatches++;
		$display("%0t: %s expected %0h actual %0h", $time, what, want, seen);
	endtask

	always @(posedge clk or negedge arst_n) begin
		trace_res_t want;
		trace_res_t got;
		if (!arst_n) begin
			threshold = HOT_THRESHOLD_RST;
			be_limit = BACKEDGE_LIMIT_RST;
			recording = 1'b0;
			foreach (hot_count[i])
				hot_count[i] = '0;
			head_pc = '0;
			fill = '0;
			be_seen = '0;
			expected_events.delete();
			mismatches = 0;
			n_results = 0;
			n_started = 0;
			n_committed = 0;
			n_aborted = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_HOT_THRESHOLD: threshold = cfg_data;
					CFG_BACKEDGE_LIMIT: be_limit = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_events.push_back(predict_trace_step(cmd, pc, opcode, next_pc));
			if (out_valid && out_ready) begin
				got.ev = ev_t'(event_res);
				got.hdr = header_address;
				got.idx = entry_index;
				got.op = entry_opcode;
				got.addr = entry_address;
				n_results++;
				if (expected_events.size() == 0) begin
					mismatches++;
					$display("%0t: result with event %0d expected none actual one",
						$time, event_res);
				end else begin
					want = expected_events.pop_front();
					if (got.ev !== want.ev)
						flag("event_res", 16'(want.ev), 16'(event_res));
					if (got.hdr !== want.hdr)
						flag("header_address", want.hdr, got.hdr);
					if (got.idx !== want.idx)
						flag("entry_index", 16'(want.idx), 16'(got.idx));
					if (got.op !== want.op)
						flag("entry_opcode", 16'(want.op), 16'(got.op));
					if (got.addr !== want.addr)
						flag("entry_address", want.addr, got.addr);
					case (want.ev)
						EV_START: n_started++;
						EV_COMMIT: n_committed++;
						EV_RESTART: begin
							n_started++;
							n_aborted++;
						end
						EV_FULL, EV_BACKEDGE: n_aborted++;
						default: ;
					endcase
				end
			end
			pending <= expected_events.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
	import htd_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic cmd = 1'b0;
	logic [ADDR_BITS-1:0] pc = '0;
	logic [7:0] opcode = '0;
	logic [ADDR_BITS-1:0] next_pc = '0;
	logic out_ready = 1'b0;

	logic in_ready;
	logic out_valid;
	logic [2:0] event_res;
	logic [15:0] header_address;
	logic [7:0] entry_index;
	logic [7:0] entry_opcode;
	logic [15:0] entry_address;

	int mismatches;
	int pending;
	int n_results;
	int n_started;
	int n_committed;
	int n_aborted;

	int tx_idle_pct = 28;
	int rx_idle_pct = 80;
	bit stall_req = 1'b0;
	bit stall_ack = 1'b0;
	int hold_left = 0;
	int quiet = 0;
	int items_sent = 0;
	logic [15:0] loop_pool [6];
	int close_mix [3] = '{0, 10, 50};

	always #4 clk = ~clk;

	hot_trace_detector_recorder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.pc(pc),
		.opcode(opcode),
		.next_pc(next_pc),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.header_address(header_address),
		.entry_index(entry_index),
		.entry_opcode(entry_opcode),
		.entry_address(entry_address)
	);

	trace_event_check event_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.pc(pc),
		.opcode(opcode),
		.next_pc(next_pc),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_res(event_res),
		.header_address(header_address),
		.entry_index(entry_index),
		.entry_opcode(entry_opcode),
		.entry_address(entry_address),
		.mismatches(mismatches),
		.pending(pending),
		.n_results(n_results),
		.n_started(n_started),
		.n_committed(n_committed),
		.n_aborted(n_aborted)
	);

	// Result side: random back-pressure, or a long hold-off when requested
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_req != stall_ack) begin
			stall_ack <= stall_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Offer one item, with random idle cycles ahead of it; return at its accept edge.
	task automatic offer(input logic c, input logic [15:0] a, input logic [7:0] op,
			input logic [15:0] npc);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		pc <= a;
		opcode <= op;
		next_pc <= npc;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Drop valid, wait out every expected result, then let the pipeline drain.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Upper bits of the limit write are junk on purpose; only the low nibble counts.
	task automatic load_regs(input logic [7:0] thr, input logic [3:0] lim);
		cfg_we <= 1'b1;
		cfg_index <= CFG_HOT_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= CFG_BACKEDGE_LIMIT;
		cfg_data <= {4'($urandom_range(15)), lim};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Run a loop: header step, body of simple steps, closing ']' back to the header.
	task automatic run_loop(input logic [15:0] h, input int body, input int iters,
			input int close_pct);
		logic [15:0] a;
		logic [7:0] op;
		logic [15:0] npc;
		for (int i = 0; i < iters; i++) begin
			offer(CMD_HEADER, h, 8'h5B, (body == 0) ? h : h + 16'd1);
			for (int k = 1; k <= body; k++) begin
				a = h + 16'(k);
				if (k == body) begin
					op = CLOSE_OP;
					npc = h;
				end else if ($urandom_range(99) < close_pct) begin
					op = CLOSE_OP;
					npc = 16'($urandom);
				end else begin
					op = 8'($urandom);
					npc = a + 16'd1;
				end
				offer(CMD_SIMPLE, a, op, npc);
			end
		end
	endtask

	task automatic run_phase(input logic [7:0] thr, input logic [3:0] lim, input int budget,
			input int self_iters);
		int stop;
		int pick;
		int body;
		int len;
		logic [15:0] h;
		load_regs(thr, lim);
		if (self_iters != 0)
			run_loop(16'($urandom), 0, self_iters, 0);
		stop = items_sent + budget;
		while (items_sent < stop) begin
			pick = $urandom_range(99);
			h = loop_pool[$urandom_range(5)];
			if (pick < 70) begin
				pick = $urandom_range(9);
				if (pick < 7)
					body = $urandom_range(0, 6);
				else if (pick < 9)
					body = $urandom_range(7, 20);
				else
					body = $urandom_range(120, 134);
				run_loop(h, body, (body > 100) ? $urandom_range(1, 2) : $urandom_range(1, 12),
					close_mix[$urandom_range(2)]);
			end else if (pick < 85) begin
				// noise: loose items, partly aimed at known headers
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					offer(1'($urandom_range(1)),
						($urandom_range(3) == 0) ? h : 16'($urandom),
						($urandom_range(3) == 0) ? CLOSE_OP : 8'($urandom),
						($urandom_range(2) == 0) ? h : 16'($urandom));
			end else begin
				// broken loop: never returns, sometimes long enough to fill the buffer
				len = ($urandom_range(3) == 0) ? $urandom_range(126, 130) : $urandom_range(1, 8);
				offer(CMD_HEADER, h, 8'h5B, h + 16'd1);
				for (int k = 1; k <= len; k++)
					offer(CMD_SIMPLE, h + 16'(k), 8'($urandom), h + 16'(k + 1));
				offer(CMD_HEADER, $urandom_range(1) ? h : 16'($urandom), 8'($urandom),
					16'($urandom));
			end
		end
		settle();
	endtask

	initial begin
		foreach (loop_pool[i])
			loop_pool[i] = 16'($urandom);
		loop_pool[1] = loop_pool[0] ^ 16'h0400;	// same counter slot as entry 0
		loop_pool[5] = 16'hFFF0;			// body wraps past the top of the address space

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, every header hot at once, no back edge tolerated
		load_regs(8'd0, 4'd0);
		offer(CMD_SIMPLE, 16'hFFFF, 8'hFF, 16'hFFFF);
		offer(CMD_HEADER, 16'h0000, 8'h00, 16'h0000);
		offer(CMD_SIMPLE, 16'h0001, CLOSE_OP, 16'h1234);
		offer(CMD_HEADER, 16'hFFFF, 8'hFF, 16'h0000);
		offer(CMD_SIMPLE, 16'h0000, 8'h00, 16'hFFFF);
		offer(CMD_HEADER, 16'h0400, 8'h5B, 16'h0401);
		offer(CMD_HEADER, 16'h8000, 8'h80, 16'h0400);
		offer(CMD_SIMPLE, 16'h5555, 8'hAA, 16'hAAAA);
		offer(CMD_HEADER, 16'hAAAA, 8'h55, 16'h5555);
		offer(CMD_SIMPLE, 16'hAAAB, CLOSE_OP, 16'hAAAA);
		offer(CMD_HEADER, 16'h1234, 8'h7F, 16'h1235);
		offer(CMD_SIMPLE, 16'h1235, CLOSE_OP, 16'h0000);
		settle();

		run_phase(8'd0, 4'd15, 220, 0);
		run_phase(8'd3, 4'd2, 220, 0);

		tx_idle_pct = 80;
		rx_idle_pct = 28;
		// saturate one counter before it may start at the top threshold
		run_phase(8'd254, 4'd0, 220, 270);
		stall_req <= ~stall_req;
		run_phase(8'd17, 4'd7, 220, 0);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(8'd100, 4'd5, 220, 0);
		run_phase(8'd1, 4'd15, 220, 0);

		$display("Sent %0d items over seven register settings; checked %0d results.",
			items_sent, n_results);
		$display("Recordings started %0d, committed %0d, aborted %0d.",
			n_started, n_committed, n_aborted);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/htd_pkg.sv
hdl/hot_trace_detector_recorder.sv
tb/trace_event_check.sv
tb/tb_top.sv
